/* rtl/core/stbs_pkg.sv */
// Shared types and constants for the sorted table binary search block.
package stbs_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 128;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned IDX_W = 7;
  localparam int unsigned CNT_W = 8;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  localparam logic [KEY_W-1:0] NOT_FOUND = {KEY_W{1'b1}};

  // controller to datapath
  typedef struct packed {
    logic wr;        // store a table entry
    logic load;      // start a search
    logic step;      // evaluate one probe
    logic out_load;  // capture the result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;     // search range is empty at start
    logic done;      // current probe ends the search
  } dp_sts_t;

endpackage

/* rtl/core/stbs_ctrl.sv */
// Controller state machine for the sorted table binary search block.
module stbs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_req_type,
  output logic            out_valid,
  input  logic            out_ready,
  input  stbs_pkg::dp_sts_t sts,
  output stbs_pkg::dp_cmd_t cmd
);
  import stbs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_SEARCH) begin
            cmd.load  = 1'b1;
            state_nxt = sts.empty ? ST_FINISH : ST_SEARCH;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (sts.done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register can take the result
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/core/stbs_dp.sv */
// Datapath for the sorted table binary search block: table memory, bounds, result.
module stbs_dp #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr,
  input  logic [stbs_pkg::CNT_W-1:0]          cfg_data,
  input  logic [stbs_pkg::IDX_W-1:0]          in_entry_index,
  input  logic signed [stbs_pkg::KEY_W-1:0]   in_entry_value,
  input  logic signed [stbs_pkg::KEY_W-1:0]   in_search_key,
  input  stbs_pkg::dp_cmd_t                   cmd,
  output stbs_pkg::dp_sts_t                   sts,
  output logic                                out_found,
  output logic signed [stbs_pkg::KEY_W-1:0]   out_matched_value
);
  import stbs_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned MW = (CW > CNT_W) ? CW : CNT_W;
  localparam int unsigned IW = (CW > IDX_W) ? CW : IDX_W;

  logic [KEY_W-1:0] mem [TABLE_DEPTH];

  logic [CNT_W-1:0] entry_count_r;
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] rdata_r;
  logic [CW-1:0]    lo_r, lo_nxt;
  logic [CW-1:0]    hi_r, hi_nxt;   // exclusive upper bound
  logic [CW-1:0]    mid_r, mid_nxt;
  logic             hit_r;
  logic             found_r;
  logic [KEY_W-1:0] value_r;

  logic [MW-1:0] cnt_ext;
  logic [MW-1:0] cnt_lim;
  logic [CW-1:0] cnt_sat;
  logic          idx_ok;
  logic          eq, lt;
  logic [CW:0]   mid_sum;

  // clamp the count to the table depth
  assign cnt_ext = MW'(entry_count_r);
  assign cnt_lim = (cnt_ext > MW'(TABLE_DEPTH)) ? MW'(TABLE_DEPTH) : cnt_ext;
  assign cnt_sat = CW'(cnt_lim);

  assign idx_ok = IW'(in_entry_index) < IW'(TABLE_DEPTH);

  assign eq = (rdata_r == key_r);
  assign lt = ($signed(rdata_r) < $signed(key_r));

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.load) begin
      lo_nxt = '0;
      hi_nxt = cnt_sat;
    end else if (cmd.step && !eq) begin
      if (lt) begin
        lo_nxt = mid_r + CW'(1);
      end else begin
        hi_nxt = mid_r;
      end
    end
    mid_sum = {1'b0, lo_nxt} + {1'b0, hi_nxt} - (CW + 1)'(1);
    mid_nxt = mid_r;
    if ((cmd.load || cmd.step) && (lo_nxt < hi_nxt)) begin
      mid_nxt = CW'(mid_sum >> 1);
    end
  end

  assign sts.empty = (cnt_sat == '0);
  assign sts.done  = eq || !(lo_nxt < hi_nxt);

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr && idx_ok) begin
      mem[AW'(in_entry_index)] <= in_entry_value;
    end
    rdata_r <= mem[AW'(mid_nxt)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_wr) begin
      entry_count_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    if (cmd.load) begin
      key_r <= in_search_key;
      hit_r <= 1'b0;
    end else if (cmd.step) begin
      hit_r <= eq;
    end
    if (cmd.out_load) begin
      found_r <= hit_r;
      value_r <= hit_r ? key_r : NOT_FOUND;
    end
  end

  assign out_found         = found_r;
  assign out_matched_value = value_r;

endmodule

/* rtl/core/sorted_table_binary_search.sv */
// Top level of the sorted table binary search block.
//
// Usage:
//   Load the key table with write transfers on the in_ channel (in_req_type = 0,
//   in_entry_index, in_entry_value), in ascending key order. A write to an index
//   at or beyond TABLE_DEPTH is dropped. Set the number of entries a search
//   covers with a transfer on the cfg_ channel (cfg_data); cfg_ready is always
//   high. Write it only while the block is idle.
//   A search transfer (in_req_type = 1, in_search_key) yields one transfer on
//   the out_ channel: out_found and out_matched_value (the key when found,
//   -1 when not). Write transfers yield nothing.
// Sequence:
//   A write leaves the block idle. A search over n covered entries is accepted,
//   then takes up to floor(log2 n) + 1 probes (one table read per cycle through
//   the single memory read port), then loads the output register once it is
//   free. One item is worked at a time.
// Reset and stall:
//   rst_n clears the control state and the entry count; table contents stay
//   undefined until written. If the receiver stalls, a finished search holds
//   until out_ready; the block keeps taking writes and one more search meanwhile.
module sorted_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [stbs_pkg::CNT_W-1:0]        cfg_data,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic [stbs_pkg::IDX_W-1:0]        in_entry_index,
  input  logic signed [stbs_pkg::KEY_W-1:0] in_entry_value,
  input  logic signed [stbs_pkg::KEY_W-1:0] in_search_key,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_found,
  output logic signed [stbs_pkg::KEY_W-1:0] out_matched_value
);
  import stbs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // the count register takes a write in any cycle
  assign cfg_ready = 1'b1;

  // sequence accept, probe and result hand-off
  stbs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // table memory, search bounds and output register
  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .in_entry_index    (in_entry_index),
    .in_entry_value    (in_entry_value),
    .in_search_key     (in_search_key),
    .cmd               (cmd),
    .sts               (sts),
    .out_found         (out_found),
    .out_matched_value (out_matched_value)
  );

endmodule

/* tb/tb_sorted_table_binary_search.sv */
// Self-checking testbench for the sorted table binary search block.
`timescale 1ns / 100ps

module tb_sorted_table_binary_search;
  import stbs_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 500;
  localparam int SETTLE_CYCLES = 12;      // outlasts the longest search
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_REPORTS = 10;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  // table content styles
  localparam int SPREAD_WIDE = 0;
  localparam int SPREAD_NARROW = 1;
  localparam int SPREAD_EXTREMES = 2;

  // receiver ready patterns
  localparam int READY_ALWAYS = 0;
  localparam int READY_RANDOM = 1;
  localparam int READY_ONE_IN_THREE = 2;
  localparam int READY_LONG_STALLS = 3;

  typedef struct packed {
    logic                    found;
    logic signed [KEY_W-1:0] value;
  } lookup_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CNT_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_req_type = REQ_WRITE;
  logic [IDX_W-1:0]        in_entry_index = '0;
  logic signed [KEY_W-1:0] in_entry_value = '0;
  logic signed [KEY_W-1:0] in_search_key = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_found;
  logic signed [KEY_W-1:0] out_matched_value;

  // Our own copy of the block state: the key table and the covered count.
  logic signed [KEY_W-1:0] key_model [DEPTH];
  int                      covered_count = 0;

  // Search results still owed by the block, oldest first.
  lookup_result_t          pending_lookups [$];

  int fail_count = 0;
  int cycle_count = 0;
  int random_items = 0;
  int burst_left = 1;
  bit sender_gaps = 1'b1;
  int stall_mode = READY_ALWAYS;
  int stall_left = 0;
  int stall_phase = 0;

  always #6 clk = ~clk;

  sorted_table_binary_search dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_entry_index    (in_entry_index),
    .in_entry_value    (in_entry_value),
    .in_search_key     (in_search_key),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_matched_value (out_matched_value)
  );

  // Binary search over the covered part of the model table, low <= high so that
  // a one-entry range is still probed. A count above the depth saturates.
  function automatic lookup_result_t lookup_key(input logic signed [KEY_W-1:0] key);
    int lo;
    int hi;
    int mid;
    int span;
    lookup_result_t r;
    span = (covered_count > DEPTH) ? DEPTH : covered_count;
    lo = 0;
    hi = span - 1;
    r.found = 1'b0;
    r.value = NOT_FOUND;
    while (lo <= hi && !r.found) begin
      mid = lo + (hi - lo) / 2;
      if (key_model[mid] == key) begin
        r.found = 1'b1;
        r.value = key;
      end else if (key_model[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return r;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  // Present one item and hold it until the transfer; then update the model and
  // possibly close the current burst with a gap of idle cycles.
  task automatic send_item(input logic req, input logic [IDX_W-1:0] idx,
                           input logic signed [KEY_W-1:0] value,
                           input logic signed [KEY_W-1:0] key);
    int gap;
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_entry_index <= idx;
    in_entry_value <= value;
    in_search_key  <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (req == REQ_WRITE) begin
      if (idx < DEPTH) key_model[idx] = value;
    end else begin
      pending_lookups.push_back(lookup_key(key));
    end
    random_items++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = sender_gaps ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_entry(input logic [IDX_W-1:0] idx, input logic signed [KEY_W-1:0] value);
    send_item(REQ_WRITE, idx, value, $urandom);
  endtask

  task automatic search_for(input logic signed [KEY_W-1:0] key);
    send_item(REQ_SEARCH, IDX_W'($urandom_range(0, DEPTH - 1)), $urandom, key);
  endtask

  // Drop valid and hold until every owed result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_lookups.size() != 0) @(posedge clk);
  endtask

  // Change the covered count only while the block is idle: drain, let any
  // trailing table write settle, then do one cfg transfer.
  task automatic write_entry_count(input logic [CNT_W-1:0] count);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    covered_count = count;
    cfg_valid <= 1'b0;
  endtask

  // Fill entries 0..span-1 with ascending keys, written in a rotated order.
  task automatic load_sorted_table(input int span, input int spread);
    logic signed [KEY_W-1:0] vals [DEPTH];
    logic signed [KEY_W-1:0] v;
    int j;
    int start;
    for (int i = 0; i < span; i++) begin
      if (spread == SPREAD_NARROW) v = int'($urandom_range(0, 16)) - 8;
      else v = $urandom;
      j = i;
      while (j > 0 && vals[j-1] > v) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = v;
    end
    if (spread == SPREAD_EXTREMES && span > 0) begin
      vals[0] = KEY_MIN;
      vals[span-1] = KEY_MAX;
    end
    start = (span > 0) ? $urandom_range(0, span - 1) : 0;
    for (int k = 0; k < span; k++) begin
      write_entry(IDX_W'((start + k) % span), vals[(start + k) % span]);
    end
  endtask

  // Mostly keys that are in the table or just next to one, some corner keys,
  // the rest anything at all.
  function automatic logic signed [KEY_W-1:0] pick_search_key(input int span);
    int sel;
    int pos;
    sel = $urandom_range(0, 9);
    pos = (span > 0) ? $urandom_range(0, span - 1) : 0;
    if (span > 0 && sel < 5) return key_model[pos];
    if (span > 0 && sel == 5) return key_model[pos] + 1;
    if (span > 0 && sel == 6) return key_model[pos] - 1;
    if (sel == 7) begin
      case ($urandom_range(0, 3))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return '0;
        default: return NOT_FOUND;
      endcase
    end
    return $urandom;
  endfunction

  // Receiver: stall on the pattern currently selected.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      case (stall_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_RANDOM: out_ready <= 1'($urandom_range(0, 1));
        READY_ONE_IN_THREE: begin
          out_ready <= (stall_phase == 0);
          stall_phase <= (stall_phase == 2) ? 0 : stall_phase + 1;
        end
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(5, 20);
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Compare every result transfer with the oldest owed lookup.
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_lookups.size() == 0) begin
        note_failure($sformatf("result with nothing owed: found=%0b value=%0d",
                               out_found, out_matched_value));
      end else begin
        want = pending_lookups.pop_front();
        if (out_found !== want.found) begin
          note_failure($sformatf("found: expected %0b, got %0b", want.found, out_found));
        end
        if (out_matched_value !== want.value) begin
          note_failure($sformatf("matched_value: expected %0d, got %0d",
                                 want.value, out_matched_value));
        end
      end
    end
  end

  // Searches on an empty table, first at the reset count, then after writing zero.
  task automatic test_empty_table();
    search_for('0);
    write_entry_count(8'd0);
    search_for(KEY_MIN);
  endtask

  // Extreme keys at both ends of a three-entry table, -1 as a real key.
  task automatic test_boundary_keys();
    write_entry(7'd0, KEY_MIN);
    write_entry(7'd1, NOT_FOUND);
    write_entry(7'd2, KEY_MAX);
    write_entry(7'd127, '0);
    write_entry_count(8'd3);
    search_for(KEY_MIN);
    search_for(NOT_FOUND);
    search_for(KEY_MAX);
    search_for('0);
    search_for(KEY_MAX - 1);
  endtask

  // One- and two-entry ranges, where the low <= high bound matters.
  task automatic test_short_ranges();
    write_entry_count(8'd1);
    search_for(KEY_MIN);
    search_for(NOT_FOUND);
    write_entry_count(8'd2);
    search_for(NOT_FOUND);
    search_for(KEY_MAX);
  endtask

  // Out-of-order table: the probes skip past a key that is present.
  task automatic test_unsorted_table();
    write_entry(7'd0, 32'sd10);
    write_entry(7'd1, -32'sd50);
    write_entry(7'd2, 32'sd3);
    write_entry_count(8'd3);
    search_for(32'sd10);
    search_for(32'sd3);
  endtask

  // Phases of table loads followed by searches, under varying count, idling and
  // stall patterns. The second phase fills the whole table, the third covers it
  // with a count beyond the depth; later phases load random spans.
  task automatic test_random_phases();
    int phase;
    int span;
    int n_search;
    int pick;
    bit broken;
    logic [CNT_W-1:0] count;
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (phase == 1) count = CNT_W'(DEPTH);
      else if (phase == 2) count = {CNT_W{1'b1}};
      else if (phase > 2 && $urandom_range(0, 7) == 0)
        count = CNT_W'($urandom_range(DEPTH + 1, 255));
      else if ($urandom_range(0, 5) == 0) count = CNT_W'($urandom_range(17, DEPTH - 1));
      else count = CNT_W'($urandom_range(0, 16));
      span = (count > DEPTH) ? DEPTH : count;
      write_entry_count(count);
      sender_gaps = ($urandom_range(0, 3) != 0);
      stall_mode <= $urandom_range(READY_ALWAYS, READY_LONG_STALLS);
      broken = ($urandom_range(0, 4) == 0);
      if (phase != 2) load_sorted_table(span, $urandom_range(SPREAD_WIDE, SPREAD_EXTREMES));
      n_search = $urandom_range(10, 30);
      for (int k = 0; k < n_search; k++) begin
        pick = $urandom_range(0, 39);
        if (pick == 0) begin
          drain_results();
        end else if (pick < 4 && span < DEPTH) begin
          // scribble past the covered range; no search reads it
          write_entry(IDX_W'($urandom_range(span, DEPTH - 1)), $urandom);
        end else if (pick < 7 && broken && span > 0) begin
          // break the ordering inside the covered range
          write_entry(IDX_W'($urandom_range(0, span - 1)), $urandom);
        end
        search_for(pick_search_key(span));
      end
      phase++;
    end
  endtask

  // Watchdog: end a hung run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    stall_mode <= READY_RANDOM;
    test_empty_table();
    test_boundary_keys();
    test_short_ranges();
    test_unsorted_table();
    test_random_phases();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_lookups.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
